// File: rtl/core/pivt_pkg.sv
// Shared types and constants for the page interval variance tracker.
`default_nettype none
package pivt_pkg;
  localparam int PageEntriesDefault = 1024;
  localparam int ScaleShiftDefault  = 10;
  localparam int IndexWidth = 10;
  localparam int TimeWidth  = 64;
  localparam int CountWidth = 32;
  localparam int StatWidth  = 64;
  localparam int StatusWidth = 2;

  localparam logic [StatusWidth-1:0] ST_INIT   = 2'd0;
  localparam logic [StatusWidth-1:0] ST_SKIP   = 2'd1;
  localparam logic [StatusWidth-1:0] ST_UPDATE = 2'd2;

  localparam logic [CountWidth-1:0] COUNT_MAX = '1;

  // one queued job from the front end to the back end
  typedef struct packed {
    logic [IndexWidth-1:0] page_index;
    logic [TimeWidth-1:0]  timestamp;
  } job_t;
endpackage
`default_nettype wire

// File: rtl/core/pivt_if.sv
// Valid/ready channel interfaces for the tracker.
`default_nettype none
interface pivt_in_if;
  logic        valid;
  logic        ready;
  logic [9:0]  page_index;
  logic [63:0] timestamp;
  modport source (output valid, page_index, timestamp, input ready);
  modport sink   (input valid, page_index, timestamp, output ready);
endinterface

interface pivt_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] sample_count;
  logic [63:0] avg_interval;
  logic [63:0] spread_sum;
  modport source (output valid, status, sample_count, avg_interval, spread_sum,
                  input ready);
  modport sink   (input valid, status, sample_count, avg_interval, spread_sum,
                  output ready);
endinterface
`default_nettype wire

// File: rtl/core/pivt_queue.sv
// Two-entry job queue between the front end and the record engine.
`default_nettype none
module pivt_queue
  import pivt_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire job_t push_data,
  output logic      full,
  input  wire logic pop,
  output job_t      pop_data,
  output logic      empty
);
  job_t slots [2];
  logic wptr, rptr;
  logic [1:0] fill;

  assign full = (fill == 2'd2);
  assign empty = (fill == 2'd0);
  assign pop_data = slots[rptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wptr] <= push_data;
    end
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push && !full) wptr <= ~wptr;
      if (pop && !empty) rptr <= ~rptr;
      fill <= fill + {1'b0, push && !full} - {1'b0, pop && !empty};
    end
  end
endmodule
`default_nettype wire

// File: rtl/core/pivt_engine.sv
// Record engine: memory access, clearing sweep, iterative divide and M2 update.
`default_nettype none
module pivt_engine
  import pivt_pkg::*;
#(
  parameter int PAGE_ENTRIES = PageEntriesDefault,
  parameter int SCALE_SHIFT  = ScaleShiftDefault
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic job_valid,
  input  wire job_t job,
  output logic      job_pop,
  output logic      busy_clear,
  pivt_out_if.source res
);
  localparam int AW = (PAGE_ENTRIES > 1) ? $clog2(PAGE_ENTRIES) : 1;
  localparam int RW = TimeWidth + CountWidth + 2 * StatWidth;
  // reciprocal for the index reduction; estimate is low by at most one
  localparam int RECIP = (1 << 20) / PAGE_ENTRIES;

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_READ  = 8'b0000_0100,
    S_EVAL  = 8'b0000_1000,
    S_DIV   = 8'b0001_0000,
    S_MUL   = 8'b0010_0000,
    S_WRITE = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_t;

  state_t state;
  logic [RW-1:0] mem [PAGE_ENTRIES];
  logic [RW-1:0] rdata;
  logic [AW-1:0] addr, clr_addr;
  logic [TimeWidth-1:0] now, x, x_next;
  logic [TimeWidth-1:0] rd_time;
  logic [CountWidth-1:0] cnt, rd_cnt;
  logic [StatWidth-1:0] mean, m2, delta, delta_next, m2_next;
  logic [StatWidth-1:0] rd_mean, rd_m2;
  logic [StatusWidth-1:0] st;
  // divider
  logic neg;
  logic [63:0] quo, rem_dividend;
  logic [CountWidth:0] remd;
  logic [6:0] bit_ctr;
  logic [CountWidth:0] trial;
  logic [63:0] prod;
  // multiplier: 3 partial products of 32x32, low 64 bits kept
  logic [1:0] mul_step;
  logic [63:0] d2;
  logic [63:0] pp;

  logic [AW-1:0] job_addr;
  logic [31:0] idx_prod, idx_quo, idx_rem;
  assign idx_prod = 32'(job.page_index) * 32'(RECIP);
  assign idx_quo  = idx_prod >> 20;
  assign idx_rem  = 32'(job.page_index) - idx_quo * 32'(PAGE_ENTRIES);
  assign job_addr = AW'((idx_rem >= 32'(PAGE_ENTRIES)) ?
                        idx_rem - 32'(PAGE_ENTRIES) : idx_rem);

  assign rd_time = rdata[RW-1 -: TimeWidth];
  assign rd_cnt  = rdata[2*StatWidth +: CountWidth];
  assign rd_mean = rdata[StatWidth +: StatWidth];
  assign rd_m2   = rdata[0 +: StatWidth];

  assign x_next     = (now - rd_time) << SCALE_SHIFT;
  assign delta_next = x_next - rd_mean;
  assign m2_next    = (st == ST_UPDATE) ?
                      m2 + 64'($signed(prod) >>> SCALE_SHIFT) : m2;

  assign job_pop = (state == S_IDLE) && job_valid;
  assign busy_clear = (state == S_CLEAR);
  assign trial = {remd[CountWidth-1:0], rem_dividend[63]};

  always_comb begin
    case (mul_step)
      2'd1: pp = 64'(delta[31:0]) * 64'(d2[31:0]);
      2'd2: pp = 64'(delta[63:32]) * 64'(d2[31:0]);
      2'd3: pp = 64'(delta[31:0]) * 64'(d2[63:32]);
      default: pp = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == S_CLEAR) mem[clr_addr] <= '0;
    else if (state == S_WRITE) mem[addr] <= {now, cnt, mean, m2_next};
    rdata <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_addr <= '0;
      res.valid <= 1'b0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (32'(clr_addr) == PAGE_ENTRIES - 1) state <= S_IDLE;
        end
        S_IDLE: if (job_valid) begin
          addr <= job_addr;
          now <= job.timestamp;
          state <= S_READ;
        end
        S_READ: state <= S_EVAL;
        S_EVAL: begin
          if (rd_time == '0) begin
            cnt <= 32'd1; mean <= '0; m2 <= '0; st <= ST_INIT;
            state <= S_WRITE;
          end else if (now <= rd_time) begin
            st <= ST_SKIP;
            state <= S_OUT;
            res.valid <= 1'b1;
            res.status <= ST_SKIP;
            res.sample_count <= rd_cnt;
            res.avg_interval <= rd_mean;
            res.spread_sum <= rd_m2;
          end else begin
            st <= ST_UPDATE;
            mean <= rd_mean;
            m2 <= rd_m2;
            x <= x_next;
            delta <= delta_next;
            neg <= delta_next[63];
            rem_dividend <= delta_next[63] ? 64'(0) - delta_next : delta_next;
            cnt <= (rd_cnt != COUNT_MAX) ? rd_cnt + 32'd1 : rd_cnt;
            remd <= '0;
            quo <= '0;
            bit_ctr <= 7'd0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          // restoring divide, one quotient bit per cycle
          if (trial >= {1'b0, cnt}) begin
            remd <= trial - {1'b0, cnt};
            quo <= {quo[62:0], 1'b1};
          end else begin
            remd <= trial;
            quo <= {quo[62:0], 1'b0};
          end
          rem_dividend <= {rem_dividend[62:0], 1'b0};
          bit_ctr <= bit_ctr + 1'b1;
          if (bit_ctr == 7'd63) state <= S_MUL;
          mul_step <= 2'd0;
          prod <= '0;
        end
        S_MUL: begin
          if (mul_step == 2'd0) begin
            mean <= mean + (neg ? 64'(0) - quo : quo);
            d2 <= x - (mean + (neg ? 64'(0) - quo : quo));
            mul_step <= 2'd1;
          end else begin
            case (mul_step)
              2'd1: prod <= pp;
              default: prod <= prod + {pp[31:0], 32'd0};
            endcase
            mul_step <= mul_step + 2'd1;
            if (mul_step == 2'd3) begin
              state <= S_WRITE;
            end
          end
        end
        S_WRITE: begin
          m2 <= m2_next;
          state <= S_OUT;
          res.valid <= 1'b1;
          res.status <= st;
          res.sample_count <= cnt;
          res.avg_interval <= mean;
          res.spread_sum <= m2_next;
        end
        S_OUT: if (res.ready) begin
          res.valid <= 1'b0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: rtl/core/pivt_front.sv
// Front end: takes input beats and queues them as jobs.
`default_nettype none
module pivt_front
  import pivt_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  pivt_in_if.sink    src,
  input  wire logic  hold,
  input  wire logic  job_pop,
  output logic       job_valid,
  output job_t       job
);
  logic full, empty;
  job_t in_job;
  assign in_job = '{page_index: src.page_index, timestamp: src.timestamp};
  assign src.ready = !full && !hold && !rst;
  assign job_valid = !empty;

  pivt_queue u_queue (
    .clk(clk), .rst(rst),
    .push(src.valid && src.ready), .push_data(in_job), .full(full),
    .pop(job_pop), .pop_data(job), .empty(empty)
  );
endmodule
`default_nettype wire

// File: rtl/core/page_interval_variance_tracker_top.sv
// Top level of the page interval variance tracker.
// Channels: in (page_index, timestamp) and out (status, sample_count,
// avg_interval, spread_sum), both valid/ready; a beat moves when both are high.
// Each input beat gives exactly one output beat, in order.
// The front end queues up to two beats while the engine works, so input keeps
// flowing during a stall of the receiver until the queue fills.
// An update passes through the restoring divide by the sample count and
// the four-step 32x32 multiply for the M2 product; a first sample skips both,
// and a rewind skips the record write as well.
// The engine takes the next job from the queue only after the receiver takes
// the previous result.
// Reset: synchronous rst starts a clearing sweep over all PAGE_ENTRIES entries of
// the record memory; no input is taken until it ends.
// When out.ready is low the result holds and the engine waits.
`default_nettype none
module page_interval_variance_tracker_top
  import pivt_pkg::*;
#(
  parameter int PAGE_ENTRIES = PageEntriesDefault,
  parameter int SCALE_SHIFT  = ScaleShiftDefault
) (
  input wire logic clk,
  input wire logic rst,
  pivt_in_if.sink    in_ch,
  pivt_out_if.source out_ch
);
  logic job_valid, job_pop, busy_clear;
  job_t job;

  // front: accept and queue
  pivt_front u_front (
    .clk(clk), .rst(rst), .src(in_ch), .hold(busy_clear),
    .job_pop(job_pop), .job_valid(job_valid), .job(job)
  );

  // back: per-record update
  pivt_engine #(.PAGE_ENTRIES(PAGE_ENTRIES), .SCALE_SHIFT(SCALE_SHIFT)) u_engine (
    .clk(clk), .rst(rst), .job_valid(job_valid), .job(job),
    .job_pop(job_pop), .busy_clear(busy_clear), .res(out_ch)
  );
endmodule
`default_nettype wire

// File: rtl/core/pivt_checker.sv
// Port-level checker for the tracker, bound to the top level.
`default_nettype none
module pivt_checker
  import pivt_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [1:0] status,
  input wire logic [31:0] sample_count
);
  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_INIT || status == ST_SKIP || status == ST_UPDATE))
    else $error("bad status");
  a_init_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_INIT |-> sample_count == 32'd1) else $error("init count");
  a_upd_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_UPDATE |-> sample_count >= 32'd2)
    else $error("update count");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status)) else $error("hold");
  a_no_take_in_reset: assert property (@(posedge clk)
    rst |-> !in_ready) else $error("ready in reset");
endmodule

bind page_interval_variance_tracker_top pivt_checker u_checker (
  .clk(clk), .rst(rst), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .status(out_ch.status), .sample_count(out_ch.sample_count)
);
`default_nettype wire
